// ----- rtl/priority_front_insert_queue_macros.svh -----
// Assertion macros for the priority front insert queue.
`ifndef PRIORITY_FRONT_INSERT_QUEUE_MACROS_SVH
`define PRIORITY_FRONT_INSERT_QUEUE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PFQ_ASSERT_NOW(label, clock, rstn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PFQ_ASSERT_NEXT(label, clock, rstn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pfq_pkg.sv -----
// Shared types and constants for the priority front insert queue.
package pfq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int ID_WIDTH    = 16;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = ADDR_W + 1;
    localparam int ENTRY_W     = ID_WIDTH + 1;
    localparam int FIELD_ID_W  = 16;
    localparam int OCC_W       = 7;

    typedef enum logic [1:0] {
        FUNC_PUSH_GEN = 2'd0,
        FUNC_PUSH_PRI = 2'd1,
        FUNC_POP      = 2'd2,
        FUNC_NOP      = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        func_t                   func;
        logic [FIELD_ID_W-1:0]   member_id;
    } cmd_t;

    typedef struct packed {
        status_t                 status;
        logic                    popped_valid;
        logic [FIELD_ID_W-1:0]   popped_id;
        logic                    popped_priority;
        logic [OCC_W-1:0]        occupancy;
    } rsp_t;

    typedef struct packed {
        logic                    we;
        logic [ADDR_W-1:0]       waddr;
        logic [ENTRY_W-1:0]      wdata;
        logic [ADDR_W-1:0]       raddr;
    } mem_req_t;

    typedef struct packed {
        logic                    done;
        status_t                 status;
        logic                    pop_valid;
        logic [CNT_W-1:0]        count;
    } ctrl_stat_t;

endpackage

// ----- rtl/pfq_ram.sv -----
// Single-port-write, registered-read RAM holding the queue entries.
module pfq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 17,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/pfq_ctrl.sv -----
// Head/count ring control: address generation, status and result strobe.
module pfq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  pfq_pkg::cmd_t       cmd,
    output pfq_pkg::mem_req_t   mem_req,
    output pfq_pkg::ctrl_stat_t stat
);

    logic [pfq_pkg::ADDR_W-1:0] head_reg, head_next;
    logic [pfq_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                       done_reg, done_next;
    pfq_pkg::status_t           status_reg, status_next;
    logic                       popv_reg, popv_next;

    logic                       full;
    logic                       empty;
    logic [pfq_pkg::SUM_W-1:0]  tail_sum;
    logic [pfq_pkg::ADDR_W-1:0] tail;
    logic [pfq_pkg::ADDR_W-1:0] head_dec;
    logic [pfq_pkg::ADDR_W-1:0] head_inc;

    assign full     = count_reg == pfq_pkg::CNT_W'(pfq_pkg::QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign tail_sum = pfq_pkg::SUM_W'(head_reg) + pfq_pkg::SUM_W'(count_reg);
    assign tail     = (tail_sum >= pfq_pkg::SUM_W'(pfq_pkg::QUEUE_DEPTH))
                    ? pfq_pkg::ADDR_W'(tail_sum - pfq_pkg::SUM_W'(pfq_pkg::QUEUE_DEPTH))
                    : pfq_pkg::ADDR_W'(tail_sum);
    assign head_dec = (head_reg == '0) ? pfq_pkg::ADDR_W'(pfq_pkg::QUEUE_DEPTH - 1)
                                       : head_reg - 1'b1;
    assign head_inc = (head_reg == pfq_pkg::ADDR_W'(pfq_pkg::QUEUE_DEPTH - 1)) ? '0
                                       : head_reg + 1'b1;

    always_comb
    begin
        head_next     = head_reg;
        count_next    = count_reg;
        done_next     = accept;
        status_next   = pfq_pkg::STAT_OK;
        popv_next     = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.waddr = tail;
        mem_req.wdata = {1'b0, cmd.member_id[pfq_pkg::ID_WIDTH-1:0]};
        mem_req.raddr = head_reg;
        if (accept)
        begin
            unique case (cmd.func)
                pfq_pkg::FUNC_PUSH_GEN:
                begin
                    if (full)
                    begin
                        status_next = pfq_pkg::STAT_FULL;
                    end
                    else
                    begin
                        mem_req.we = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                pfq_pkg::FUNC_PUSH_PRI:
                begin
                    if (full)
                    begin
                        status_next = pfq_pkg::STAT_FULL;
                    end
                    else
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = head_dec;
                        mem_req.wdata = {1'b1, cmd.member_id[pfq_pkg::ID_WIDTH-1:0]};
                        head_next     = head_dec;
                        count_next    = count_reg + 1'b1;
                    end
                end
                pfq_pkg::FUNC_POP:
                begin
                    if (empty)
                    begin
                        status_next = pfq_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        // RAM captures the head entry at this edge
                        popv_next  = 1'b1;
                        head_next  = head_inc;
                        count_next = count_reg - 1'b1;
                    end
                end
                pfq_pkg::FUNC_NOP:
                begin
                    status_next = pfq_pkg::STAT_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        popv_reg   <= popv_next;
    end

    assign stat.done      = done_reg;
    assign stat.status    = status_reg;
    assign stat.pop_valid = popv_reg;
    assign stat.count     = count_reg;

endmodule

// ----- rtl/priority_front_insert_queue.sv -----
// Priority front insert queue top level: ring control plus entry RAM.
// Latency: a command accepted at edge N gives its result beat in the following cycle.
// Throughput: one command per cycle; busy stays low, the ring RAM reads the head every cycle.
// Reset: rst_n clears head, count and the result strobe; RAM contents are not cleared.
// Results are one-cycle beats marked by done; the receiver cannot stall.
`include "priority_front_insert_queue_macros.svh"

module priority_front_insert_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  pfq_pkg::cmd_t cmd,
    output logic          done,
    output pfq_pkg::rsp_t rsp
);

    pfq_pkg::mem_req_t          mem_req;
    pfq_pkg::ctrl_stat_t        stat;
    logic [pfq_pkg::ENTRY_W-1:0] rdata;
    logic                       accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    pfq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .cmd     (cmd),
        .mem_req (mem_req),
        .stat    (stat)
    );

    pfq_ram #(
        .DEPTH (pfq_pkg::QUEUE_DEPTH),
        .WIDTH (pfq_pkg::ENTRY_W),
        .AW    (pfq_pkg::ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (rdata)
    );

    assign done                = stat.done;
    assign rsp.status          = stat.status;
    assign rsp.popped_valid    = stat.pop_valid;
    assign rsp.popped_id       = stat.pop_valid
                               ? pfq_pkg::FIELD_ID_W'(rdata[pfq_pkg::ID_WIDTH-1:0]) : '0;
    assign rsp.popped_priority = stat.pop_valid & rdata[pfq_pkg::ID_WIDTH];
    assign rsp.occupancy       = pfq_pkg::OCC_W'(stat.count);

    `PFQ_ASSERT_NEXT(a_accept_gives_beat, clk, rst_n, accept, done, "accepted command without result beat")
    `PFQ_ASSERT_NEXT(a_no_spurious_beat, clk, rst_n, !accept, !done, "result beat without command")
    `PFQ_ASSERT_NOW(a_pop_status_ok, clk, rst_n, done && rsp.popped_valid, rsp.status == pfq_pkg::STAT_OK, "pop beat with error status")
    `PFQ_ASSERT_NOW(a_occ_bound, clk, rst_n, 1'b1, stat.count <= pfq_pkg::CNT_W'(pfq_pkg::QUEUE_DEPTH), "entry count above capacity")

endmodule

// ----- test/tb_priority_front_insert_queue.sv -----
// Self-checking testbench for the priority front insert queue: directed, boundary and random beats.
`timescale 1ns / 1ps

module tb_priority_front_insert_queue;
    import pfq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    cmd_t  cmd;
    logic  done;
    rsp_t  rsp;

    priority_front_insert_queue uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    // predicted queue contents
    logic [ID_WIDTH-1:0] ring_id [QUEUE_DEPTH];
    logic                ring_pri [QUEUE_DEPTH];
    int                  ring_head;
    int                  ring_count;

    rsp_t pending_rsp [$];
    rsp_t want_rsp;
    rsp_t next_rsp;
    int   n_accepted;
    int   n_mismatch;
    int   n_fail;
    int   cycle_count;
    int   idle_pct;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic predict_queue_op(input cmd_t c, output rsp_t r);
        int pos;
        begin
            r = '0;
            r.status = STAT_OK;
            case (c.func)
                FUNC_PUSH_GEN, FUNC_PUSH_PRI:
                begin
                    if (ring_count >= QUEUE_DEPTH)
                    begin
                        r.status = STAT_FULL;
                    end
                    else if (c.func == FUNC_PUSH_GEN)
                    begin
                        pos = (ring_head + ring_count) % QUEUE_DEPTH;
                        ring_id[pos]  = c.member_id[ID_WIDTH-1:0];
                        ring_pri[pos] = 1'b0;
                        ring_count++;
                    end
                    else
                    begin
                        ring_head = (ring_head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                        ring_id[ring_head]  = c.member_id[ID_WIDTH-1:0];
                        ring_pri[ring_head] = 1'b1;
                        ring_count++;
                    end
                end
                FUNC_POP:
                begin
                    if (ring_count == 0)
                    begin
                        r.status = STAT_EMPTY;
                    end
                    else
                    begin
                        r.popped_valid    = 1'b1;
                        r.popped_id       = FIELD_ID_W'(ring_id[ring_head]);
                        r.popped_priority = ring_pri[ring_head];
                        ring_head = (ring_head + 1) % QUEUE_DEPTH;
                        ring_count--;
                    end
                end
                default: ;
            endcase
            r.occupancy = OCC_W'(ring_count);
        end
    endtask

    task automatic report_mismatch(input string what, input rsp_t w, input rsp_t s);
        begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("%s: exp st=%0d v=%0b id=%h pr=%0b occ=%0d got st=%0d v=%0b id=%h pr=%0b occ=%0d",
                         what, w.status, w.popped_valid, w.popped_id, w.popped_priority,
                         w.occupancy, s.status, s.popped_valid, s.popped_id,
                         s.popped_priority, s.occupancy);
        end
    endtask

    // result check and prediction of each accepted beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_rsp.size() == 0)
                begin
                    report_mismatch("unexpected beat", '0, rsp);
                end
                else
                begin
                    want_rsp = pending_rsp.pop_front();
                    if (rsp.status !== want_rsp.status ||
                        rsp.popped_valid !== want_rsp.popped_valid ||
                        rsp.popped_id !== want_rsp.popped_id ||
                        rsp.popped_priority !== want_rsp.popped_priority ||
                        rsp.occupancy !== want_rsp.occupancy)
                        report_mismatch("mismatch", want_rsp, rsp);
                end
            end
            if (start && !busy)
            begin
                predict_queue_op(cmd, next_rsp);
                pending_rsp.push_back(next_rsp);
                n_accepted++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("priority_front_insert_queue verification failed");
            $finish;
        end
    end

    task automatic send_beat(input func_t f, input logic [FIELD_ID_W-1:0] id);
        int   mark;
        cmd_t junk;
        begin
            while ($urandom_range(0, 99) < idle_pct)
            begin
                junk.func      = func_t'($urandom_range(0, 3));
                junk.member_id = FIELD_ID_W'($urandom);
                @(negedge clk);
                start <= 1'b0;
                cmd   <= junk;
            end
            @(negedge clk);
            mark = n_accepted;
            start         <= 1'b1;
            cmd.func      <= f;
            cmd.member_id <= id;
            wait (n_accepted != mark);
        end
    endtask

    task automatic wait_drain();
        begin
            @(negedge clk);
            start <= 1'b0;
            while (pending_rsp.size() != 0)
                @(posedge clk);
            repeat (3) @(posedge clk);
        end
    endtask

    function automatic logic [FIELD_ID_W-1:0] pick_id();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return FIELD_ID_W'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        begin
            send_beat(FUNC_POP, 16'h1234);
            send_beat(FUNC_NOP, 16'h0000);
            send_beat(FUNC_PUSH_GEN, 16'h0000);
            send_beat(FUNC_PUSH_GEN, 16'hFFFF);
            send_beat(FUNC_PUSH_PRI, 16'hFFFF);
            send_beat(FUNC_PUSH_PRI, 16'h0000);
            send_beat(FUNC_NOP, 16'hA5A5);
            send_beat(FUNC_POP, 16'hFFFF);
            send_beat(FUNC_POP, 16'h0000);
            send_beat(FUNC_POP, 16'h5555);
            send_beat(FUNC_POP, 16'hAAAA);
            send_beat(FUNC_POP, 16'h0000);
            send_beat(FUNC_PUSH_PRI, 16'h5A5A);
            send_beat(FUNC_POP, 16'h0000);
            send_beat(FUNC_PUSH_GEN, 16'h8001);
            send_beat(FUNC_NOP, 16'hFFFF);
            send_beat(FUNC_POP, 16'h0000);
            send_beat(FUNC_POP, 16'h0000);
        end
    endtask

    task automatic test_full_boundary();
        begin
            while (ring_count < QUEUE_DEPTH)
                send_beat($urandom_range(0, 1) ? FUNC_PUSH_PRI : FUNC_PUSH_GEN, pick_id());
            send_beat(FUNC_PUSH_GEN, 16'hFFFF);
            send_beat(FUNC_PUSH_PRI, 16'h0000);
            send_beat(FUNC_NOP, pick_id());
            send_beat(FUNC_POP, pick_id());
            send_beat(FUNC_PUSH_PRI, pick_id());
            send_beat(FUNC_PUSH_PRI, pick_id());
            while (ring_count > 0)
                send_beat(FUNC_POP, pick_id());
            send_beat(FUNC_POP, pick_id());
        end
    endtask

    // random walk: fill, drain and balanced stretches so full and empty both recur
    task automatic test_random_walk(input int n_beats);
        int    mode;
        int    roll;
        func_t f;
        begin
            mode = 0;
            for (int i = 0; i < n_beats; i++)
            begin
                if (i % 40 == 0)
                    mode = $urandom_range(0, 2);
                roll = $urandom_range(0, 99);
                case (mode)
                    0:       f = (roll < 75) ? FUNC_PUSH_GEN : (roll < 95) ? FUNC_POP : FUNC_NOP;
                    1:       f = (roll < 75) ? FUNC_POP : (roll < 95) ? FUNC_PUSH_GEN : FUNC_NOP;
                    default: f = (roll < 47) ? FUNC_PUSH_GEN : (roll < 94) ? FUNC_POP : FUNC_NOP;
                endcase
                if (f == FUNC_PUSH_GEN && $urandom_range(0, 1))
                    f = FUNC_PUSH_PRI;
                send_beat(f, pick_id());
            end
        end
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        ring_head   = 0;
        ring_count  = 0;
        n_accepted  = 0;
        n_mismatch  = 0;
        n_fail      = 0;
        cycle_count = 0;
        idle_pct    = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        wait_drain();
        test_full_boundary();
        wait_drain();
        idle_pct = 61;
        test_random_walk(200);
        wait_drain();
        idle_pct = 10;
        test_full_boundary();
        test_random_walk(200);
        wait_drain();
        idle_pct = 0;
        test_random_walk(200);

        @(negedge clk);
        start <= 1'b0;
        for (int k = 0; k < 200 && pending_rsp.size() != 0; k++)
            @(posedge clk);
        repeat (4) @(posedge clk);
        n_fail = n_mismatch + pending_rsp.size();
        if (n_fail == 0)
            $display("priority_front_insert_queue verification clean");
        else
            $display("priority_front_insert_queue verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/pfq_pkg.sv
rtl/pfq_ram.sv
rtl/pfq_ctrl.sv
rtl/priority_front_insert_queue.sv
test/tb_priority_front_insert_queue.sv
